// ----- rtl/fst_pkg.sv -----
// shared types and command codes of the frame sequence timer
package fst_pkg;

	localparam int CMD_W       = 3;
	localparam int DELTA_W     = 16;
	localparam int DUR_IN_W    = 16;
	localparam int FRAME_OUT_W = 4;

	localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PAUSE  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RESUME = 3'd2;
	localparam logic [CMD_W-1:0] CMD_STOP   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RESET  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SKIP   = 3'd5;
	localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd6;

	typedef logic [2:0] op_t;

	localparam op_t OP_NOP    = 3'd0;
	localparam op_t OP_TICK   = 3'd1;
	localparam op_t OP_PAUSE  = 3'd2;
	localparam op_t OP_RESUME = 3'd3;
	localparam op_t OP_STOP   = 3'd4;
	localparam op_t OP_RESET  = 3'd5;
	localparam op_t OP_SKIP   = 3'd6;
	localparam op_t OP_LOAD   = 3'd7;

	typedef struct packed {
		op_t                 op;
		logic [DELTA_W-1:0]  delta;
		logic                mirror;
		logic [DUR_IN_W-1:0] dur;
	} item_t;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

// ----- rtl/fst_front.sv -----
// input stage: accepts a transaction and decodes its command
module fst_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [fst_pkg::CMD_W-1:0]     command,
	input  logic [fst_pkg::DELTA_W-1:0]   delta_ms,
	input  logic                          mirror_request,
	input  logic [fst_pkg::DUR_IN_W-1:0]  frame_duration,
	output logic                          push_valid,
	output fst_pkg::item_t                push_item,
	input  logic                          push_full
);

	logic           valid_s1;
	fst_pkg::item_t item_s1;
	fst_pkg::op_t   op_dec;
	logic           take;

	assign in_stall   = valid_s1 && push_full;
	assign take       = in_valid && !in_stall;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_comb begin
		unique case (command)
			fst_pkg::CMD_TICK:   op_dec = fst_pkg::OP_TICK;
			fst_pkg::CMD_PAUSE:  op_dec = fst_pkg::OP_PAUSE;
			fst_pkg::CMD_RESUME: op_dec = fst_pkg::OP_RESUME;
			fst_pkg::CMD_STOP:   op_dec = fst_pkg::OP_STOP;
			fst_pkg::CMD_RESET:  op_dec = fst_pkg::OP_RESET;
			fst_pkg::CMD_SKIP:   op_dec = fst_pkg::OP_SKIP;
			fst_pkg::CMD_LOAD:   op_dec = fst_pkg::OP_LOAD;
			default:             op_dec = fst_pkg::OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (!push_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.op     <= op_dec;
			item_s1.delta  <= delta_ms;
			item_s1.mirror <= mirror_request;
			item_s1.dur    <= frame_duration;
		end
	end

endmodule

// ----- rtl/fst_queue.sv -----
// short queue of decoded commands between front and back
module fst_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  fst_pkg::item_t push_item,
	output logic           push_full,
	output logic           pop_valid,
	output fst_pkg::item_t pop_item,
	input  logic           pop
);

	fst_pkg::item_t                   ent_q [fst_pkg::QUEUE_DEPTH];
	logic [fst_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [fst_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [fst_pkg::QCNT_W-1:0]       cnt_q;
	logic                             do_push;
	logic                             do_pop;

	assign push_full = (cnt_q == fst_pkg::QCNT_W'(fst_pkg::QUEUE_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_item  = ent_q[rd_ptr_q];
	assign do_push   = push_valid && !push_full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + fst_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + fst_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + fst_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - fst_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- rtl/fst_div.sv -----
// bit-serial remainder unit, one quotient bit per cycle
module fst_div #(
	parameter int N_W = 21,
	parameter int D_W = 20
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] num,
	input  logic [D_W-1:0] den,
	output logic           done,
	output logic [D_W-1:0] rem
);

	localparam int CNT_W = $clog2(N_W + 1);

	logic [N_W-1:0]   num_q;
	logic [D_W-1:0]   rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [D_W:0]     trial;
	logic [D_W:0]     diff;

	assign trial = {rem_q, num_q[N_W-1]};
	assign diff  = trial - {1'b0, den};
	assign done  = done_q;
	assign rem   = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(N_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= num_q << 1;
			rem_q <= diff[D_W] ? trial[D_W-1:0] : diff[D_W-1:0];
		end
	end

endmodule

// ----- rtl/fst_back.sv -----
// executor: duration table, playback state, frame walk and result register
module fst_back #(
	parameter int MAX_FRAMES    = 16,
	parameter int DURATION_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             loop_enable,
	input  logic                             pop_valid,
	input  fst_pkg::item_t                   pop_item,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [fst_pkg::FRAME_OUT_W-1:0]  frame_index,
	output logic                             done_flag,
	output logic                             paused_flag,
	output logic                             mirrored
);

	localparam int DW    = DURATION_BITS;
	localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CNT_W = $clog2(MAX_FRAMES + 1);
	localparam int TOT_W = DW + CNT_W;
	localparam int SUM_W = ((TOT_W > fst_pkg::DELTA_W) ? TOT_W : fst_pkg::DELTA_W) + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_EX   = 3'd3;
	localparam logic [2:0] ST_RES  = 3'd4;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] fl_q;
	logic [TOT_W-1:0] total_q;
	logic [TOT_W-1:0] elapsed_q;
	logic [IDX_W-1:0] cur_q;
	logic             done_q;
	logic             paused_q;
	logic             mirror_q;
	logic             mirror_pend_q;
	logic             out_valid_q;

	logic [DW-1:0]    mem [MAX_FRAMES];
	logic [DW-1:0]    rd_q;

	logic [31:0]      dur_ext;
	logic [DW-1:0]    dur_w;
	logic             playing;
	logic             div_start;
	logic             div_done;
	logic [TOT_W-1:0] div_rem;
	logic [SUM_W-1:0] sum;
	logic [CNT_W-1:0] nxt;
	logic [TOT_W-1:0] rd_ext;
	logic             load_ok;
	logic             out_free;
	logic [31:0]      cur_ext;

	assign dur_ext   = 32'(pop_item.dur);
	assign dur_w     = dur_ext[DW-1:0];
	assign playing   = !paused_q && !done_q && (fl_q != '0) && (total_q != '0);
	assign pop       = (state_q == ST_IDLE) && pop_valid;
	assign div_start = pop && (pop_item.op == fst_pkg::OP_TICK) && playing;
	assign sum       = SUM_W'(elapsed_q) + SUM_W'(pop_item.delta);
	assign nxt       = CNT_W'(cur_q) + CNT_W'(1);
	assign rd_ext    = TOT_W'(rd_q);
	assign load_ok   = (fl_q != CNT_W'(MAX_FRAMES));
	assign out_free  = !out_valid_q || !out_stall;
	assign cur_ext   = 32'(cur_q);
	assign out_valid = out_valid_q;

	fst_div #(
		.N_W (SUM_W),
		.D_W (TOT_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (sum),
		.den    (total_q),
		.done   (div_done),
		.rem    (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			fl_q          <= '0;
			total_q       <= '0;
			elapsed_q     <= '0;
			cur_q         <= '0;
			done_q        <= 1'b0;
			paused_q      <= 1'b0;
			mirror_q      <= 1'b0;
			mirror_pend_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_RES;
						unique case (pop_item.op)
							fst_pkg::OP_TICK: begin
								if (playing) begin
									state_q       <= ST_DIV;
									mirror_pend_q <= pop_item.mirror;
									if (CNT_W'(cur_q) >= fl_q) begin
										cur_q <= '0;
									end
								end
							end
							fst_pkg::OP_PAUSE:  paused_q <= 1'b1;
							fst_pkg::OP_RESUME: paused_q <= 1'b0;
							fst_pkg::OP_STOP:   done_q   <= 1'b1;
							fst_pkg::OP_RESET: begin
								done_q    <= 1'b0;
								paused_q  <= 1'b0;
								cur_q     <= '0;
								elapsed_q <= '0;
							end
							fst_pkg::OP_SKIP: begin
								done_q <= 1'b1;
								cur_q  <= (fl_q != '0) ? IDX_W'(fl_q - CNT_W'(1)) : '0;
							end
							fst_pkg::OP_LOAD: begin
								if (load_ok) begin
									fl_q    <= fl_q + CNT_W'(1);
									total_q <= total_q + TOT_W'(dur_w);
								end
							end
							default: ;
						endcase
					end
				end
				ST_DIV: begin
					if (div_done) begin
						elapsed_q <= div_rem;
						state_q   <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_EX;
				end
				ST_EX: begin
					if (elapsed_q < rd_ext) begin
						mirror_q <= mirror_pend_q;
						state_q  <= ST_RES;
					end else begin
						elapsed_q <= elapsed_q - rd_ext;
						if (nxt >= fl_q) begin
							if (loop_enable) begin
								cur_q   <= '0;
								state_q <= ST_RD;
							end else begin
								done_q   <= 1'b1;
								cur_q    <= IDX_W'(fl_q - CNT_W'(1));
								mirror_q <= mirror_pend_q;
								state_q  <= ST_RES;
							end
						end else begin
							cur_q   <= IDX_W'(nxt);
							state_q <= ST_RD;
						end
					end
				end
				ST_RES: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// duration table, one write and one registered read port
	always_ff @(posedge clk) begin
		if (pop && (pop_item.op == fst_pkg::OP_LOAD) && load_ok) begin
			mem[fl_q[IDX_W-1:0]] <= dur_w;
		end
		rd_q <= mem[cur_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_RES) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RES) && out_free) begin
			frame_index <= cur_ext[fst_pkg::FRAME_OUT_W-1:0];
			done_flag   <= done_q;
			paused_flag <= paused_q;
			mirrored    <= mirror_q;
		end
	end

endmodule

// ----- rtl/frame_sequence_timer.sv -----
// frame sequence timer top level: input stage, command queue and executor
//
// Input channel (in_valid/in_stall) carries one command per transaction:
// tick with delta_ms and mirror_request, pause, resume, stop, reset, skip,
// or load with frame_duration. Every command gives exactly one result
// transaction on the output channel (out_valid/out_stall) with the frame
// index, done, paused and mirror flags as they stand after the command.
// A played tick also runs a bit-serial remainder of (elapsed + delta) by
// the duration total, one dividend bit per cycle (22 bits at default
// sizes), then walks the frames, a read state and an examine state each,
// since the duration table has one registered read port; the walk
// examines 1 to MAX_FRAMES frames. One command at a time: the executor
// takes the next only back in idle; up to three more wait in the input
// stage and the queue. Reset clears all playback state, the frame count
// and the total; the duration table is not cleared and is only read below
// the frame count. A stalled result holds its payload; the executor then
// waits before taking the next command, and the input stalls once the
// queue fills. loop_enable is written through cfg_write/cfg_data; the user
// must do so only while the block is idle: the block does not enforce it.
module frame_sequence_timer #(
	parameter int MAX_FRAMES    = 16,
	parameter int DURATION_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic                             cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [fst_pkg::CMD_W-1:0]        command,
	input  logic [fst_pkg::DELTA_W-1:0]      delta_ms,
	input  logic                             mirror_request,
	input  logic [fst_pkg::DUR_IN_W-1:0]     frame_duration,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [fst_pkg::FRAME_OUT_W-1:0]  frame_index,
	output logic                             done_flag,
	output logic                             paused_flag,
	output logic                             mirrored
);

	logic           loop_q;
	logic           push_valid;
	fst_pkg::item_t push_item;
	logic           push_full;
	logic           pop_valid;
	fst_pkg::item_t pop_item;
	logic           pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_q <= 1'b0;
		end else if (cfg_write) begin
			loop_q <= cfg_data;
		end
	end

	fst_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.delta_ms       (delta_ms),
		.mirror_request (mirror_request),
		.frame_duration (frame_duration),
		.push_valid     (push_valid),
		.push_item      (push_item),
		.push_full      (push_full)
	);

	fst_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_full  (push_full),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop        (pop)
	);

	fst_back #(
		.MAX_FRAMES    (MAX_FRAMES),
		.DURATION_BITS (DURATION_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.loop_enable (loop_q),
		.pop_valid   (pop_valid),
		.pop_item    (pop_item),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.frame_index (frame_index),
		.done_flag   (done_flag),
		.paused_flag (paused_flag),
		.mirrored    (mirrored)
	);

endmodule
